### hw/rtl/fpas_pkg.sv
// Package for the single-precision adder/subtractor core.
// Holds the operand and result beat structs and datapath widths; no dependencies.
package fpas_pkg;

  localparam int unsigned ExpW  = 8;
  localparam int unsigned ManW  = 24;
  localparam int unsigned FracW = 23;
  localparam int unsigned WideW = 26;

  typedef struct packed {
    logic            a_sign;
    logic [ExpW-1:0] a_exp;
    logic [ManW-1:0] a_man;
    logic            b_sign;
    logic [ExpW-1:0] b_exp;
    logic [ManW-1:0] b_man;
  } fpas_in_t;

  typedef struct packed {
    logic             sum_sign;
    logic [ExpW-1:0]  sum_exp;
    logic [FracW-1:0] sum_frac;
  } fpas_out_t;

  // Aligned operands handed from the align stage to the add stage.
  typedef struct packed {
    logic             sign;
    logic             sub;
    logic [ExpW-1:0]  exp;
    logic [ManW-1:0]  big;
    logic [WideW-1:0] shifted;
    logic             lost;
  } fpas_align_t;

  // Normalized, unrounded result handed to the round stage.
  typedef struct packed {
    logic             sign;
    logic             sub;
    logic [ExpW-1:0]  exp;
    logic [WideW-1:0] man;
    logic             sticky;
  } fpas_norm_t;

endpackage

### hw/rtl/fpas_align.sv
// Align stage: picks the larger operand and shifts the smaller one right.
// Depends on fpas_pkg.
module fpas_align import fpas_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  fpas_in_t    in_beat,
  output logic        out_valid,
  output fpas_align_t out_beat
);

  fpas_align_t nxt;
  logic        a_big;
  logic [ExpW-1:0]  sh;
  logic [ManW-1:0]  lm;
  logic [WideW-1:0] lm_ext;
  logic [WideW-1:0] lost_mask;

  always_comb begin
    a_big = (in_beat.a_exp > in_beat.b_exp) ||
            ((in_beat.a_exp == in_beat.b_exp) && (in_beat.a_man >= in_beat.b_man));
    nxt.sub  = in_beat.a_sign ^ in_beat.b_sign;
    nxt.sign = a_big ? in_beat.a_sign : in_beat.b_sign;
    nxt.exp  = a_big ? in_beat.a_exp : in_beat.b_exp;
    nxt.big  = a_big ? in_beat.a_man : in_beat.b_man;
    lm       = a_big ? in_beat.b_man : in_beat.a_man;
    sh       = a_big ? (in_beat.a_exp - in_beat.b_exp) : (in_beat.b_exp - in_beat.a_exp);
    lm_ext   = {lm, 2'b00};
    // Bits of the mantissa below the round position: those under bit sh.
    lost_mask = (WideW'(1) << sh[4:0]) - WideW'(1);
    if (sh > 8'd31) begin
      nxt.shifted = '0;
      nxt.lost    = (lm != '0);
    end else begin
      nxt.shifted = lm_ext >> sh[4:0];
      nxt.lost    = ((lm_ext & lost_mask & ~WideW'(3)) != '0) && (sh > 8'd2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= in_valid;
    out_beat <= nxt;
  end

endmodule

### hw/rtl/fpas_addnorm.sv
// Add stage: adds or subtracts aligned mantissas and normalizes the result.
// Depends on fpas_pkg.
module fpas_addnorm import fpas_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  fpas_align_t in_beat,
  output logic        out_valid,
  output fpas_norm_t  out_beat
);

  fpas_norm_t nxt;
  logic [WideW:0]   s;
  logic [WideW-1:0] d;
  logic [4:0]       lz;
  logic             zero;

  always_comb begin
    s    = {1'b0, in_beat.big, 2'b00} + {1'b0, in_beat.shifted};
    d    = {in_beat.big, 2'b00} - in_beat.shifted;
    lz   = '0;
    zero = 1'b1;
    for (int i = WideW - 1; i >= 0; i--) begin
      if (zero && d[i]) begin
        lz   = 5'(WideW - 1 - i);
        zero = 1'b0;
      end
    end
    nxt.sign = in_beat.sign;
    nxt.sub  = in_beat.sub;
    if (!in_beat.sub) begin
      if (s[WideW]) begin
        nxt.exp    = in_beat.exp + 8'd1;
        nxt.man    = s[WideW:1];
        nxt.sticky = in_beat.lost || in_beat.shifted[0];
      end else begin
        nxt.exp    = in_beat.exp;
        nxt.man    = s[WideW-1:0];
        nxt.sticky = in_beat.lost;
      end
    end else begin
      nxt.sticky = 1'b0;
      if (!zero && (in_beat.exp > {3'b000, lz})) begin
        nxt.exp = in_beat.exp - {3'b000, lz};
        nxt.man = d << lz;
      end else begin
        nxt.exp = '0;
        nxt.man = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= in_valid;
    out_beat <= nxt;
  end

endmodule

### hw/rtl/fpas_round.sv
// Round stage: rounds to nearest, ties to even on additions and down on subtractions; registers the result.
// Depends on fpas_pkg.
module fpas_round import fpas_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  fpas_norm_t in_beat,
  output logic       out_valid,
  output fpas_out_t  out_beat
);

  fpas_out_t        nxt;
  logic [2:0]       g;
  logic             up;
  logic [FracW-1:0] frac;

  always_comb begin
    g    = {in_beat.man[1:0], in_beat.sticky};
    frac = in_beat.man[FracW+1:2];
    up   = (g > 3'd4) || ((g == 3'd4) && !in_beat.sub && frac[0]);
    nxt.sum_sign = in_beat.sign;
    nxt.sum_exp  = in_beat.exp;
    nxt.sum_frac = frac;
    if (up) begin
      if (frac == '1) begin
        nxt.sum_exp  = in_beat.exp + 8'd1;
        nxt.sum_frac = '0;
      end else begin
        nxt.sum_frac = frac + FracW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= in_valid;
    out_beat <= nxt;
  end

endmodule

### hw/rtl/fp32_adder_subtractor_core.sv
// Top level of the single-precision adder/subtractor core.
// Instantiates fpas_align, fpas_addnorm and fpas_round; uses fpas_pkg.
//
//  Channel  | Ports            | Handshake
//  ---------+------------------+----------------------------------------
//  operands | start, busy, op  | beat taken when start is high, busy low
//  result   | done, res        | beat shown for one cycle while done high
//
// Each beat passes in order through the align, add/normalize and round stages, each registered.
// A new beat may enter every cycle, so busy is tied low.
// The receiver cannot stall, so no beat ever waits inside the pipeline.
// Synchronous reset clears the stage valid bits; data registers are not reset.
module fp32_adder_subtractor_core import fpas_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  fpas_in_t  op,
  output logic      done,
  output fpas_out_t res
);

  logic        v1, v2;
  fpas_align_t s1;
  fpas_norm_t  s2;

  assign busy = 1'b0;

  fpas_align u_align (
    .clk(clk), .rst(rst), .in_valid(start && !busy), .in_beat(op),
    .out_valid(v1), .out_beat(s1)
  );

  fpas_addnorm u_addnorm (
    .clk(clk), .rst(rst), .in_valid(v1), .in_beat(s1),
    .out_valid(v2), .out_beat(s2)
  );

  fpas_round u_round (
    .clk(clk), .rst(rst), .in_valid(v2), .in_beat(s2),
    .out_valid(done), .out_beat(res)
  );

  // Operands taken by the align stage come out of the round stage as a result; none are lost in the pipeline.
  assert property (@(posedge clk) disable iff (rst)
    ($past(start, 3) && $past(v1, 2) && $past(v2)) |-> done)
    else $error("result beat lost in pipeline");

  // Cancelled differences flush to an all-zero exponent and fraction.
  assert property (@(posedge clk) disable iff (rst)
    (v2 && s2.sub && s2.man == '0) |=> (res.sum_exp == '0 && res.sum_frac == '0))
    else $error("zero difference not flushed");

  // The sign of the result comes from the kept operand.
  assert property (@(posedge clk) disable iff (rst)
    v2 |=> (res.sum_sign == $past(s2.sign)))
    else $error("result sign mismatch");

endmodule
